/* design/gbn_pkg.sv */
// Shared types, codes and parameter defaults of the Go-Back-N sender window.
package gbn_pkg;

    localparam int MAX_SEQ_DEF      = 7;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic [1:0] ACT_NEW     = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_REFUSED = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RESEND
    } t_state;

endpackage

/* design/gbn_in_if.sv */
// Input channel of the sender window: action, payload and ack number.
interface gbn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] payload;
    logic [2:0]  ack_number;

    modport source (output valid, output action, output payload, output ack_number,
                    input ready);
    modport sink   (input valid, input action, input payload, input ack_number,
                    output ready);
endinterface

/* design/gbn_out_if.sv */
// Result channel of the sender window: one result item per transfer.
interface gbn_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  frame_seq;
    logic [31:0] frame_payload;
    logic [2:0]  released_count;
    logic [2:0]  outstanding_after;
    logic        last;

    modport source (output valid, output result_kind, output frame_seq,
                    output frame_payload, output released_count,
                    output outstanding_after, output last, input ready);
    modport sink   (input valid, input result_kind, input frame_seq,
                    input frame_payload, input released_count,
                    input outstanding_after, input last, output ready);
endinterface

/* design/go_back_n_sender_window.sv */
// Go-Back-N sender window: a new payload or an acknowledgement gives one result in the
// next cycle; a timeout with N frames outstanding gives N results, one per cycle
// while the sink keeps up, through the single read port of the payload RAM, and the next item
// is taken no earlier than the edge at which the last of them leaves the output register.
// The payload RAM needs no clearing after reset; only outstanding entries are ever read.
module go_back_n_sender_window #(
    parameter int MAX_SEQ      = gbn_pkg::MAX_SEQ_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gbn_in_if.sink           i_req,
    gbn_out_if.source        o_rsp
);

    localparam int SEQ_MOD = MAX_SEQ + 1;
    localparam int SEQ_W   = $clog2(SEQ_MOD);
    localparam int CNT_W   = SEQ_W;
    localparam int DIF_W   = ((SEQ_W > 3) ? SEQ_W : 3) + 1;
    localparam int STORE_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

    gbn_pkg::t_state r_state, n_state;

    logic [SEQ_W-1:0] r_next_seq, n_next_seq;
    logic [SEQ_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0] r_outstanding, n_outstanding;

    logic [SEQ_W-1:0] r_rd_seq;
    logic [CNT_W-1:0] r_rd_left;
    logic             r_pend;
    logic [SEQ_W-1:0] r_pend_seq;
    logic             r_pend_last;

    logic        r_o_valid, n_o_valid;
    logic [1:0]  r_o_kind, n_o_kind;
    logic [2:0]  r_o_seq, n_o_seq;
    logic [31:0] r_o_pay, n_o_pay;
    logic [2:0]  r_o_rel, n_o_rel;
    logic [2:0]  r_o_outs, n_o_outs;
    logic        r_o_last, n_o_last;

    logic               out_free;
    logic               in_ready;
    logic               accept;
    logic               rd_en;
    logic               pend_load;
    logic               full;
    logic               wr_en;
    logic [STORE_W-1:0] pay_masked;
    logic [STORE_W-1:0] rd_data;

    logic [DIF_W-1:0]   ack_ext;
    logic [DIF_W-1:0]   old_ext;
    logic [DIF_W-1:0]   ack_gap;
    logic               ack_hit;
    logic [CNT_W-1:0]   rel;
    logic [SEQ_W:0]     old_sum;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
        logic [SEQ_W-1:0] r;
        r = (a == SEQ_W'(MAX_SEQ)) ? '0 : a + 1'b1;
        return r;
    endfunction

    gbn_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SEQ_MOD)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_next_seq),
        .i_wr_data (pay_masked),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_seq),
        .o_rd_data (rd_data)
    );

    assign pay_masked = STORE_W'(i_req.payload);
    assign full       = (r_outstanding == CNT_W'(MAX_SEQ));

    // cumulative ack distance from the oldest unacked frame
    always_comb begin
        ack_ext = DIF_W'(i_req.ack_number);
        old_ext = DIF_W'(r_oldest);
        ack_gap = ack_ext - old_ext;
        if (ack_ext < old_ext) begin
            ack_gap = ack_gap + DIF_W'(SEQ_MOD);
        end
        ack_hit = (ack_ext < DIF_W'(SEQ_MOD)) && (ack_gap < DIF_W'(r_outstanding));
        rel     = ack_hit ? CNT_W'(ack_gap + 1'b1) : '0;
        old_sum = (SEQ_W+1)'(r_oldest) + (SEQ_W+1)'(rel);
        if (old_sum >= (SEQ_W+1)'(SEQ_MOD)) begin
            old_sum = old_sum - (SEQ_W+1)'(SEQ_MOD);
        end
    end

    // handshake and read control
    always_comb begin
        out_free  = !r_o_valid || o_rsp.ready;
        in_ready  = (r_state == gbn_pkg::ST_IDLE) && out_free;
        accept    = i_req.valid && in_ready;
        pend_load = r_pend && out_free;
        rd_en     = (r_state == gbn_pkg::ST_RESEND) && (r_rd_left != '0)
                    && (!r_pend || out_free);
        wr_en     = accept && (i_req.action == gbn_pkg::ACT_NEW) && !full;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbn_pkg::ST_IDLE: begin
                if (accept && (i_req.action == gbn_pkg::ACT_TIMEOUT)
                    && (r_outstanding != '0)) begin
                    n_state = gbn_pkg::ST_RESEND;
                end
            end
            gbn_pkg::ST_RESEND: begin
                if ((r_rd_left == '0) && !r_pend) begin
                    n_state = gbn_pkg::ST_IDLE;
                end
            end
            default: n_state = gbn_pkg::ST_IDLE;
        endcase
    end

    // window state and output register
    always_comb begin
        n_next_seq    = r_next_seq;
        n_oldest      = r_oldest;
        n_outstanding = r_outstanding;
        n_o_valid     = r_o_valid && !o_rsp.ready;
        n_o_kind      = r_o_kind;
        n_o_seq       = r_o_seq;
        n_o_pay       = r_o_pay;
        n_o_rel       = r_o_rel;
        n_o_outs      = r_o_outs;
        n_o_last      = r_o_last;
        if (accept) begin
            case (i_req.action)
                gbn_pkg::ACT_NEW: begin
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b1;
                    n_o_rel   = '0;
                    if (full) begin
                        n_o_kind = gbn_pkg::KIND_REFUSED;
                        n_o_seq  = '0;
                        n_o_pay  = '0;
                        n_o_outs = 3'(r_outstanding);
                    end else begin
                        n_outstanding = r_outstanding + 1'b1;
                        n_next_seq    = seq_inc(r_next_seq);
                        n_o_kind      = gbn_pkg::KIND_DATA;
                        n_o_seq       = 3'(r_next_seq);
                        n_o_pay       = 32'(pay_masked);
                        n_o_outs      = 3'(n_outstanding);
                    end
                end
                gbn_pkg::ACT_ACK: begin
                    n_oldest      = SEQ_W'(old_sum);
                    n_outstanding = r_outstanding - rel;
                    n_o_valid     = 1'b1;
                    n_o_last      = 1'b1;
                    n_o_kind      = gbn_pkg::KIND_ACK;
                    n_o_seq       = '0;
                    n_o_pay       = '0;
                    n_o_rel       = 3'(rel);
                    n_o_outs      = 3'(n_outstanding);
                end
                default: begin
                end
            endcase
        end else if (pend_load) begin
            n_o_valid = 1'b1;
            n_o_kind  = gbn_pkg::KIND_DATA;
            n_o_seq   = 3'(r_pend_seq);
            n_o_pay   = 32'(rd_data);
            n_o_rel   = '0;
            n_o_outs  = 3'(r_outstanding);
            n_o_last  = r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gbn_pkg::ST_IDLE;
            r_next_seq    <= '0;
            r_oldest      <= '0;
            r_outstanding <= '0;
            r_rd_left     <= '0;
            r_pend        <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_next_seq    <= n_next_seq;
            r_oldest      <= n_oldest;
            r_outstanding <= n_outstanding;
            r_o_valid     <= n_o_valid;
            if (accept && (i_req.action == gbn_pkg::ACT_TIMEOUT)) begin
                r_rd_left <= r_outstanding;
            end else if (rd_en) begin
                r_rd_left <= r_rd_left - 1'b1;
            end
            if (rd_en) begin
                r_pend <= 1'b1;
            end else if (pend_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_kind <= n_o_kind;
        r_o_seq  <= n_o_seq;
        r_o_pay  <= n_o_pay;
        r_o_rel  <= n_o_rel;
        r_o_outs <= n_o_outs;
        r_o_last <= n_o_last;
        if (accept && (i_req.action == gbn_pkg::ACT_TIMEOUT)) begin
            r_rd_seq <= r_oldest;
        end else if (rd_en) begin
            r_rd_seq <= seq_inc(r_rd_seq);
        end
        if (rd_en) begin
            r_pend_seq  <= r_rd_seq;
            r_pend_last <= (r_rd_left == CNT_W'(1));
        end
    end

    assign i_req.ready             = in_ready;
    assign o_rsp.valid             = r_o_valid;
    assign o_rsp.result_kind       = r_o_kind;
    assign o_rsp.frame_seq         = r_o_seq;
    assign o_rsp.frame_payload     = r_o_pay;
    assign o_rsp.released_count    = r_o_rel;
    assign o_rsp.outstanding_after = r_o_outs;
    assign o_rsp.last              = r_o_last;

endmodule

/* design/gbn_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/gbn_checker.sv */
// Port-level assertions for the sender window, bound to the top level.
module gbn_checker #(
    parameter int MAX_SEQ = gbn_pkg::MAX_SEQ_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [2:0]  i_seq,
    input logic [31:0] i_pay,
    input logic [2:0]  i_rel,
    input logic [2:0]  i_outs,
    input logic        i_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_seq)
            && $stable(i_pay) && $stable(i_last))
        else $error("stalled result changed");

    a_no_input_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input taken during resend burst");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == gbn_pkg::KIND_REFUSED)
            |-> i_last && (i_outs == 3'(MAX_SEQ)) && (i_pay == '0) && (i_rel == '0))
        else $error("refusal with window not full");

    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == gbn_pkg::KIND_ACK)
            |-> i_last && (i_seq == '0) && (i_pay == '0))
        else $error("malformed ack result");

endmodule

bind go_back_n_sender_window gbn_checker #(.MAX_SEQ(MAX_SEQ)) u_gbn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_kind      (o_rsp.result_kind),
    .i_seq       (o_rsp.frame_seq),
    .i_pay       (o_rsp.frame_payload),
    .i_rel       (o_rsp.released_count),
    .i_outs      (o_rsp.outstanding_after),
    .i_last      (o_rsp.last)
);
